[design/ngrfc_pkg.sv]
// Shared types and constants for the ng-route feasibility checker.
// No dependencies; imported by ngrfc_step and ng_route_feasibility_check_core.
`default_nettype none
package ngrfc_pkg;

  localparam int CmdW    = 2;
  localparam int VertexW = 6;
  localparam int KindW   = 2;
  localparam int RowW    = 64;

  // Input tdata layout, low bit first, padded to whole bytes
  localparam int CmdLo    = 0;
  localparam int VertexLo = CmdLo + CmdW;
  localparam int KindLo   = VertexLo + VertexW;
  localparam int RowLo    = KindLo + KindW;
  localparam int InBits   = RowLo + RowW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;
  localparam int OutDataW = 8;

  typedef enum logic [CmdW-1:0] {
    CmdStart = 2'd0,
    CmdLoad  = 2'd1,
    CmdMove  = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KindTruck    = 2'd0,
    KindDrone    = 2'd1,
    KindCombined = 2'd2
  } kind_e;

endpackage
`default_nettype wire

[design/ngrfc_step.sv]
// Next-state logic for one item: forbidden-set updates and feasibility test.
// Depends on ngrfc_pkg; pure combinational, used by the core top level.
`default_nettype none
module ngrfc_step #(
  parameter int VERTEX_COUNT = 64
) (
  input  ngrfc_pkg::cmd_e                     cmd_i,
  input  logic [ngrfc_pkg::VertexW-1:0]       vertex_i,
  input  ngrfc_pkg::kind_e                    kind_i,
  input  logic [VERTEX_COUNT-1:0]             row_i,
  input  logic [VERTEX_COUNT-1:0]             truck_set_i,
  input  logic [VERTEX_COUNT-1:0]             drone_set_i,
  input  logic [ngrfc_pkg::VertexW-1:0]       truck_pos_i,
  input  logic                                with_truck_i,
  input  logic                                feasible_i,
  output logic [VERTEX_COUNT-1:0]             truck_set_o,
  output logic [VERTEX_COUNT-1:0]             drone_set_o,
  output logic [ngrfc_pkg::VertexW-1:0]       truck_pos_o,
  output logic                                with_truck_o,
  output logic                                feasible_o
);
  import ngrfc_pkg::*;

  localparam int AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam logic [VertexW:0] VxLimit = (VertexW+1)'(VERTEX_COUNT);

  logic                    vx_ok;
  logic                    kind_ok;
  logic [AddrW-1:0]        vx_addr;
  logic [VERTEX_COUNT-1:0] t_bit;
  logic [VERTEX_COUNT-1:0] drone_new;

  assign vx_ok   = ({1'b0, vertex_i} < VxLimit);
  assign kind_ok = (kind_i == KindTruck) || (kind_i == KindDrone) ||
                   (kind_i == KindCombined);
  assign vx_addr = vertex_i[AddrW-1:0];
  // out-of-range position shifts out to zero; only happens while infeasible
  assign t_bit   = {{(VERTEX_COUNT-1){1'b0}}, 1'b1} << truck_pos_i;
  assign drone_new = with_truck_i ? (truck_set_i | t_bit) : (drone_set_i | t_bit);

  always_comb begin
    truck_set_o  = truck_set_i;
    drone_set_o  = drone_set_i;
    truck_pos_o  = truck_pos_i;
    with_truck_o = with_truck_i;
    feasible_o   = feasible_i;
    unique case (cmd_i)
      CmdStart: begin
        truck_set_o  = '0;
        drone_set_o  = '0;
        truck_pos_o  = vertex_i;
        with_truck_o = 1'b1;
        feasible_o   = vx_ok;
      end
      CmdLoad: begin
        // row write happens at acceptance, nothing to do here
      end
      CmdMove: begin
        if (feasible_i && kind_ok) begin
          if (!vx_ok) begin
            feasible_o = 1'b0;
          end else begin
            drone_set_o = drone_new;
            if (kind_i == KindDrone) begin
              if (drone_new[vx_addr]) feasible_o = 1'b0;
              with_truck_o = 1'b1;
            end else begin
              if (truck_set_i[vx_addr]) feasible_o = 1'b0;
              truck_set_o = (truck_set_i | t_bit) & row_i;
              truck_pos_o = vertex_i;
              if (kind_i == KindTruck) with_truck_o = 1'b0;
            end
          end
        end
      end
      default: begin
        // unknown command: no state change
      end
    endcase
  end

endmodule
`default_nettype wire

[design/ng_route_feasibility_check_core.sv]
// ng-route feasibility checker core: stream in, one feasibility flag per item out.
// Depends on ngrfc_pkg and ngrfc_step.
//
//  channel  | dir | tdata fields (low bit first)                       | notes
//  ---------+-----+----------------------------------------------------+----------------
//  s_axis   | in  | command[1:0] vertex[7:2] move_kind[9:8]            | 80-bit tdata,
//           |     | row_bits[73:10], zero pad [79:74]                  | no tlast/tuser
//  m_axis   | out | feasible[0], zero pad [7:1]                        | 8-bit tdata
//
// Throughput: one item per clock while m_axis_tready_i stays high; an accepted item
//   passes through the stage register (with the row read) and then the result register,
//   which drives m_axis_tvalid_o.
// The row memory is read at acceptance, so its registered read port sets the first stage.
// Reset: sets are cleared, truck at vertex 0, drone with truck, feasible; the
//   neighbourhood rows are not cleared and must be loaded before a move uses them.
// Stalls: the result register holds while m_axis_tready_i is low; the input stage
//   keeps accepting until it is also occupied.
`default_nettype none
module ng_route_feasibility_check_core #(
  parameter int VERTEX_COUNT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // command[1:0], vertex[7:2], move_kind[9:8], row_bits[73:10], zero pad above
  input  logic [ngrfc_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // feasible[0], zero pad above
  output logic [ngrfc_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import ngrfc_pkg::*;

  localparam int AddrW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam logic [VertexW:0] VxLimit = (VertexW+1)'(VERTEX_COUNT);

  // input field unpack
  cmd_e               in_cmd;
  logic [VertexW-1:0] in_vertex;
  kind_e              in_kind;
  logic [RowW-1:0]    in_row;
  logic               in_vx_ok;
  logic               in_acc;

  assign in_cmd    = cmd_e'(s_axis_tdata_i[CmdLo +: CmdW]);
  assign in_vertex = s_axis_tdata_i[VertexLo +: VertexW];
  assign in_kind   = kind_e'(s_axis_tdata_i[KindLo +: KindW]);
  assign in_row    = s_axis_tdata_i[RowLo +: RowW];
  assign in_vx_ok  = ({1'b0, in_vertex} < VxLimit);

  // stage 1: accepted item plus the row it addresses
  logic                    s1_valid_q;
  cmd_e                    s1_cmd_q;
  logic [VertexW-1:0]      s1_vertex_q;
  kind_e                   s1_kind_q;
  logic [VERTEX_COUNT-1:0] row_q;
  logic                    s1_adv;

  // route state
  logic [VERTEX_COUNT-1:0] truck_set_q, truck_set_d;
  logic [VERTEX_COUNT-1:0] drone_set_q, drone_set_d;
  logic [VertexW-1:0]      truck_pos_q, truck_pos_d;
  logic                    with_truck_q, with_truck_d;
  logic                    feas_q, feas_d;

  // result register
  logic out_valid_q;
  logic out_feas_q;
  logic out_free;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // neighbourhood rows: written and read at acceptance, so a move right after
  // a load of the same row sees the new contents
  logic [VERTEX_COUNT-1:0] rows_mem [VERTEX_COUNT];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_vx_ok) begin
      if (in_cmd == CmdLoad) begin
        rows_mem[in_vertex[AddrW-1:0]] <= in_row[VERTEX_COUNT-1:0];
      end
      row_q <= rows_mem[in_vertex[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q    <= in_cmd;
      s1_vertex_q <= in_vertex;
      s1_kind_q   <= in_kind;
    end
  end

  ngrfc_step #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_step (
    .cmd_i        (s1_cmd_q),
    .vertex_i     (s1_vertex_q),
    .kind_i       (s1_kind_q),
    .row_i        (row_q),
    .truck_set_i  (truck_set_q),
    .drone_set_i  (drone_set_q),
    .truck_pos_i  (truck_pos_q),
    .with_truck_i (with_truck_q),
    .feasible_i   (feas_q),
    .truck_set_o  (truck_set_d),
    .drone_set_o  (drone_set_d),
    .truck_pos_o  (truck_pos_d),
    .with_truck_o (with_truck_d),
    .feasible_o   (feas_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_feas_q   <= 1'b0;
      truck_set_q  <= '0;
      drone_set_q  <= '0;
      truck_pos_q  <= '0;
      with_truck_q <= 1'b1;
      feas_q       <= 1'b1;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q  <= 1'b1;
        out_feas_q   <= feas_d;
        truck_set_q  <= truck_set_d;
        drone_set_q  <= drone_set_d;
        truck_pos_q  <= truck_pos_d;
        with_truck_q <= with_truck_d;
        feas_q       <= feas_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-1){1'b0}}, out_feas_q};

  // ---- assertions ----
  logic s1_vx_ok;
  assign s1_vx_ok = ({1'b0, s1_vertex_q} < VxLimit);

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_cmd_q == CmdMove && !feas_q |=> !feas_q)
    else $error("failure cleared by a move");

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_cmd_q == CmdStart |=>
      truck_set_q == '0 && drone_set_q == '0 && with_truck_q &&
      feas_q == $past(s1_vx_ok))
    else $error("start did not reinitialize route state");

  a_truck_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_cmd_q == CmdMove && s1_kind_q == KindTruck && feas_q && s1_vx_ok |=>
      !with_truck_q && truck_pos_q == $past(s1_vertex_q))
    else $error("truck move did not separate drone or advance truck");

  a_result_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid_o && out_feas_q == feas_q)
    else $error("result flag differs from route state");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input stalled with empty stage");

endmodule
`default_nettype wire

[test/ngrfc_route_scoreboard.sv]
// Scoreboard for ng_route_feasibility_check_core: follows the route state from
// accepted input items and compares every output item against it.
// Depends on ngrfc_pkg.
module ngrfc_route_scoreboard #(
  parameter int VERTEX_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // command, vertex, move_kind, row_bits, zero pad above
  input  logic [ngrfc_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // feasible, zero pad above
  input  logic [ngrfc_pkg::OutDataW-1:0] m_axis_tdata_i,
  output int                            mismatches_o,
  output int                            pending_o
);
  import ngrfc_pkg::*;

  localparam logic [RowW-1:0] SetMask =
    (VERTEX_COUNT >= RowW) ? {RowW{1'b1}} : ((64'd1 << VERTEX_COUNT) - 64'd1);

  logic [RowW-1:0]    ng_rows [1 << VertexW];
  logic [RowW-1:0]    truck_ban;
  logic [RowW-1:0]    drone_ban;
  logic [VertexW-1:0] truck_at;
  logic               drone_joined;
  logic               route_ok;
  bit                 feasible_due [$];
  bit                 want;

  // Applies one item to the shadow route state, returns the flag it yields.
  function automatic bit route_step(logic [CmdW-1:0] cmd, logic [VertexW-1:0] v,
                                    logic [KindW-1:0] kind, logic [RowW-1:0] row);
    logic [RowW-1:0] t_bit;
    logic [RowW-1:0] v_bit;
    t_bit = RowW'(1) << truck_at;
    v_bit = RowW'(1) << v;
    case (cmd)
      CmdStart: begin
        truck_ban    = '0;
        drone_ban    = '0;
        truck_at     = v;
        drone_joined = 1'b1;
        route_ok     = (int'(v) < VERTEX_COUNT);
      end
      CmdLoad: begin
        if (int'(v) < VERTEX_COUNT) ng_rows[v] = row & SetMask;
      end
      CmdMove: begin
        if (route_ok && (kind == KindTruck || kind == KindDrone || kind == KindCombined)) begin
          if (int'(v) >= VERTEX_COUNT) begin
            route_ok = 1'b0;
          end else begin
            drone_ban = drone_joined ? (truck_ban | t_bit) : (drone_ban | t_bit);
            if (kind == KindDrone) begin
              if (|(drone_ban & v_bit)) route_ok = 1'b0;
              drone_joined = 1'b1;
            end else begin
              if (|(truck_ban & v_bit)) route_ok = 1'b0;
              truck_ban = (truck_ban | t_bit) & ng_rows[v] & SetMask;
              truck_at  = v;
              if (kind == KindTruck) drone_joined = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return route_ok;
  endfunction

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      truck_ban    = '0;
      drone_ban    = '0;
      truck_at     = '0;
      drone_joined = 1'b1;
      route_ok     = 1'b1;
      feasible_due.delete();
      pending_o    = 0;
    end else begin
      // results first: they always belong to items accepted on earlier edges
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (feasible_due.size() == 0) begin
          $error("feasible: output item with nothing expected, expected none got %0d",
                 m_axis_tdata_i[0]);
          mismatches_o++;
        end else begin
          want = feasible_due.pop_front();
          if (m_axis_tdata_i[0] !== want) begin
            $error("feasible: expected %0d got %0d", want, m_axis_tdata_i[0]);
            mismatches_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        feasible_due.insert(feasible_due.size(),
                            route_step(s_axis_tdata_i[CmdLo +: CmdW],
                                       s_axis_tdata_i[VertexLo +: VertexW],
                                       s_axis_tdata_i[KindLo +: KindW],
                                       s_axis_tdata_i[RowLo +: RowW]));
      end
      pending_o = feasible_due.size();
    end
  end

endmodule

[test/tb.sv]
// Testbench top for ng_route_feasibility_check_core: drives route items with
// random gaps and output stalls, and reports the scoreboard verdict.
// Depends on ngrfc_pkg, ngrfc_route_scoreboard and the core.
module tb;
  import ngrfc_pkg::*;

  localparam int VERTEX_COUNT = 64;
  localparam int RANDOM_ITEMS = 1200;  // rough size of the random part
  localparam int CALM_ITEMS   = 200;   // tail of the run with no idling

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;
  int                  mismatches;
  int                  pending;

  int                  sent = 0;        // items accepted so far
  int                  stop_at = 0;     // item count where stimulus ends
  bit                  calm = 1'b0;     // no idling on either side
  int unsigned         stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ng_route_feasibility_check_core #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  ngrfc_route_scoreboard #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) scoreboard (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_i (in_ready),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_i (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_i  (out_data),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Output side: random stall bursts of random length, none once calm.
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 15) == 0)
      stall_left = $urandom_range(1, 19);
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Neighbourhood rows: mostly sparse so routes stay feasible for a while,
  // now and then dense, empty or fully random to reach every row bit.
  function automatic logic [RowW-1:0] pick_row();
    logic [RowW-1:0] r;
    r = '0;
    case ($urandom_range(0, 9))
      0: r = {$urandom, $urandom};
      1: r = '1;
      2: r = '0;
      default: repeat ($urandom_range(1, 6)) r[$urandom_range(0, RowW-1)] = 1'b1;
    endcase
    return r;
  endfunction

  // One item on the input channel, after an optional idle burst. Valid is
  // only lowered on a gap, so back-to-back items keep it high.
  task automatic send_item(logic [CmdW-1:0] cmd, logic [VertexW-1:0] v,
                           logic [KindW-1:0] kind, logic [RowW-1:0] row);
    logic [InDataW-1:0] word;
    int unsigned        gap;
    word = '0;
    word[CmdLo +: CmdW]       = cmd;
    word[VertexLo +: VertexW] = v;
    word[KindLo +: KindW]     = kind;
    word[RowLo +: RowW]       = row;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait for every outstanding flag.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // A well-formed route: start, then a run of moves. Some moves revisit a
  // recent vertex to provoke a failure; a few reload a row mid-route.
  task automatic run_route();
    logic [VertexW-1:0] seen [4];
    logic [VertexW-1:0] v;
    logic [KindW-1:0]   kind;
    int                 hops;
    v = $urandom_range(0, VERTEX_COUNT - 1);
    seen = '{default: v};
    send_item(CmdStart, v, KindTruck, {$urandom, $urandom});
    hops = $urandom_range(1, 30);
    for (int h = 0; h < hops; h++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(CmdLoad, VertexW'($urandom_range(0, VERTEX_COUNT - 1)),
                  KindW'($urandom), pick_row());
      end else begin
        kind = KindW'($urandom_range(KindTruck, KindCombined));
        if ($urandom_range(0, 6) == 0) v = seen[$urandom_range(0, 3)];
        else v = VertexW'($urandom_range(0, VERTEX_COUNT - 1));
        send_item(CmdMove, v, kind, {$urandom, $urandom});
        seen[h % 4] = v;
      end
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every row is written up front, so no move ever reads an unloaded row.
    for (int r = 0; r < (1 << VertexW); r++)
      send_item(CmdLoad, VertexW'(r), KindTruck, pick_row());

    // Directed part: extremes of the row bits, each command and move kind,
    // sticky failure and the ignored codes.
    send_item(CmdLoad, 6'd5, KindTruck, '1);
    send_item(CmdLoad, 6'd6, KindDrone, '0);
    send_item(CmdLoad, 6'd7, KindCombined, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(CmdLoad, 6'd63, KindTruck, 64'h5555_5555_5555_5555);
    send_item(CmdStart, 6'd0, KindTruck, '0);
    send_item(CmdMove, 6'd5, KindTruck, '0);       // drone stays behind
    send_item(CmdMove, 6'd0, KindDrone, '0);       // drone rejoins at banned vertex 0: fails
    send_item(CmdMove, 6'd0, KindCombined, '0);    // vertex 0 banned: fails
    send_item(CmdMove, 6'd63, KindTruck, '1);      // failure holds
    send_item(CmdStart, 6'd63, KindTruck, '1);
    send_item(CmdMove, 6'd63, KindW'(3), '0);      // unknown kind: ignored
    send_item(CmdW'(3), 6'd0, KindTruck, '1);      // unknown command: ignored
    send_item(CmdMove, 6'd6, KindCombined, '0);    // empty row clears truck set
    send_item(CmdMove, 6'd5, KindTruck, '0);
    send_item(CmdMove, 6'd6, KindDrone, '0);       // drone hits its own ban
    send_item(CmdStart, 6'd0, KindTruck, '0);
    send_item(CmdMove, 6'd0, KindDrone, '0);       // drone back to truck vertex
    send_item(CmdStart, 6'd1, KindTruck, '0);
    send_item(CmdMove, 6'd7, KindTruck, '0);
    send_item(CmdMove, 6'd1, KindTruck, '0);       // revisit within ng set
    send_item(CmdStart, 6'd2, KindTruck, '0);
    send_item(CmdMove, 6'd63, KindCombined, '0);
    send_item(CmdMove, 6'd62, KindDrone, '0);
    send_item(CmdMove, 6'd5, KindTruck, '0);

    // Random part: mostly routes, some noise on every field.
    stop_at = sent + RANDOM_ITEMS;
    while (sent < stop_at) begin
      if (sent >= stop_at - CALM_ITEMS) calm = 1'b1;
      if (!paused && sent >= stop_at - RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        run_route();
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(CmdW'($urandom), VertexW'($urandom), KindW'($urandom), pick_row());
      end
    end

    drain_results();
    repeat (4) @(posedge clk);  // room for any stray result past the pipeline
    if (mismatches == 0) begin
      $display("ng_route_feasibility_check_core verification clean");
    end else begin
      $display("ng_route_feasibility_check_core verification failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("ng_route_feasibility_check_core verification failed");
    $finish;
  end

endmodule

[sim.f]
design/ngrfc_pkg.sv
design/ngrfc_step.sv
design/ng_route_feasibility_check_core.sv
test/ngrfc_route_scoreboard.sv
test/tb.sv
